// ----- src/sha256_pkg.sv -----
package sha256_pkg;

   // Byte position at which the 64-bit length field starts.
   localparam logic [5:0] LEN_START = 6'd56;
   // Last byte position of a block.
   localparam logic [5:0] LAST_BYTE = 6'd63;
   // Last round of a compression.
   localparam logic [5:0] LAST_ROUND = 6'd63;
   // Last digest word.
   localparam logic [2:0] LAST_WORD = 3'd7;
   // First padding byte after the message.
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUNDS,
      ST_UPDATE
   } state_type;

   // Source of a byte shifted into the block window.
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LENGTH
   } byte_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_byte;
      byte_src_type byte_src;
      logic [2:0]   len_index;
      logic         count_byte;
      logic         start;
      logic         round_en;
      logic [5:0]   round_index;
      logic         update;
      logic         final_block;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   // Initial hash values.
   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Round constants.
   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ----- src/sha256_ctrl.sv -----
module sha256_ctrl
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tuser,
   input  logic          req_tlast,
   output logic          req_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type  state_ff, state_in;
   state_type  resume_ff, resume_in;
   logic       final_ff, final_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         resume_ff <= ST_IDLE;
         final_ff  <= 1'b0;
         fill_ff   <= '0;
         round_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         final_ff  <= final_in;
         fill_ff   <= fill_in;
         round_ff  <= round_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in        = state_ff;
      resume_in       = resume_ff;
      final_in        = final_ff;
      fill_in         = fill_ff;
      round_in        = round_ff;
      req_tready      = 1'b0;
      cmd             = '0;
      cmd.byte_src    = SRC_DATA;
      cmd.len_index   = fill_ff[2:0];
      cmd.round_index = round_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser) begin
                  cmd.load_byte  = 1'b1;
                  cmd.count_byte = 1'b1;
                  fill_in        = fill_ff + 6'd1;
                  if (fill_ff == LAST_BYTE) begin
                     // The block is full: compress it, then pad if the message ended.
                     cmd.start = 1'b1;
                     round_in  = '0;
                     final_in  = 1'b0;
                     resume_in = req_tlast ? ST_PAD_MARK : ST_IDLE;
                     state_in  = ST_ROUNDS;
                  end else if (req_tlast) begin
                     state_in = ST_PAD_MARK;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_PAD_MARK: begin
            cmd.load_byte = 1'b1;
            cmd.byte_src  = SRC_MARK;
            fill_in       = fill_ff + 6'd1;
            if (fill_ff == LAST_BYTE) begin
               cmd.start = 1'b1;
               round_in  = '0;
               resume_in = ST_PAD_ZERO;
               state_in  = ST_ROUNDS;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (fill_ff == LEN_START) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.load_byte = 1'b1;
               cmd.byte_src  = SRC_ZERO;
               fill_in       = fill_ff + 6'd1;
               // Padding ran past the length field: compress and pad another block.
               if (fill_ff == LAST_BYTE) begin
                  cmd.start = 1'b1;
                  round_in  = '0;
                  resume_in = ST_PAD_ZERO;
                  state_in  = ST_ROUNDS;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.load_byte = 1'b1;
            cmd.byte_src  = SRC_LENGTH;
            fill_in       = fill_ff + 6'd1;
            if (fill_ff == LAST_BYTE) begin
               cmd.start = 1'b1;
               round_in  = '0;
               final_in  = 1'b1;
               resume_in = ST_IDLE;
               state_in  = ST_ROUNDS;
            end
         end
         ST_ROUNDS: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The final block waits until the previous digest has drained.
            if (!(final_ff && status.out_busy)) begin
               cmd.update      = 1'b1;
               cmd.final_block = final_ff;
               final_in        = 1'b0;
               state_in        = resume_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/sha256_datapath.sv -----
module sha256_datapath
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    data_byte,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,
   output logic          rsp_tlast
);

   logic [511:0] win_ff, win_in;
   logic [63:0]  bit_length_ff, bit_length_in;
   logic [31:0]  chain_ff [8];
   logic [31:0]  chain_in [8];
   logic [31:0]  v_ff [8];
   logic [31:0]  v_in [8];
   logic [31:0]  digest_ff [8];
   logic [31:0]  digest_in [8];
   logic [31:0]  sum_v [8];
   logic         out_valid_ff, out_valid_in;
   logic [2:0]   out_index_ff, out_index_in;
   logic [7:0]   byte_mux;
   logic [31:0]  w_next;
   logic [31:0]  t1;
   logic [31:0]  t2;
   logic         out_take;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Byte source for the block window.
   always_comb begin
      case (cmd.byte_src)
         SRC_DATA:   byte_mux = data_byte;
         SRC_MARK:   byte_mux = PAD_MARK_BYTE;
         SRC_ZERO:   byte_mux = 8'h00;
         SRC_LENGTH: byte_mux = bit_length_ff[{~cmd.len_index, 3'b000} +: 8];
         default:    byte_mux = 8'h00;
      endcase
   end

   // Message schedule: word 0 sits in the top 32 bits of the window.
   assign w_next = small_sigma1(win_ff[63:32]) + win_ff[223:192]
                 + small_sigma0(win_ff[479:448]) + win_ff[511:480];

   // One compression round.
   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + (v_ff[6] ^ (v_ff[4] & (v_ff[5] ^ v_ff[6])))
             + ROUND_K[cmd.round_index] + win_ff[511:480];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & (v_ff[1] | v_ff[2])) | (v_ff[1] & v_ff[2]));

   assign out_take = out_valid_ff && rsp_tready;

   // Next values of the window, length, working, chain and output registers.
   always_comb begin
      win_in        = win_ff;
      bit_length_in = bit_length_ff;
      out_valid_in  = out_valid_ff;
      out_index_in  = out_index_ff;
      if (cmd.load_byte) begin
         win_in = {win_ff[503:0], byte_mux};
      end else if (cmd.round_en) begin
         win_in = {win_ff[479:0], w_next};
      end
      if (cmd.count_byte) begin
         bit_length_in = bit_length_ff + 64'd8;
      end else if (cmd.update && cmd.final_block) begin
         bit_length_in = '0;
      end
      for (int k = 0; k < 8; k++) begin
         sum_v[k]     = chain_ff[k] + v_ff[k];
         chain_in[k]  = chain_ff[k];
         v_in[k]      = v_ff[k];
         digest_in[k] = digest_ff[k];
      end
      if (cmd.start) begin
         for (int k = 0; k < 8; k++) begin
            v_in[k] = chain_ff[k];
         end
      end else if (cmd.round_en) begin
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
      end
      // Output stage: shift the digest one word per transaction.
      if (out_take) begin
         for (int k = 0; k < 7; k++) begin
            digest_in[k] = digest_ff[k + 1];
         end
         out_index_in = out_index_ff + 3'd1;
         if (out_index_ff == LAST_WORD) begin
            out_valid_in = 1'b0;
         end
      end
      if (cmd.update) begin
         for (int k = 0; k < 8; k++) begin
            chain_in[k] = cmd.final_block ? INIT_HASH[k] : sum_v[k];
         end
         if (cmd.final_block) begin
            for (int k = 0; k < 8; k++) begin
               digest_in[k] = sum_v[k];
            end
            out_valid_in = 1'b1;
            out_index_in = '0;
         end
      end
   end

   // Registers with a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_length_ff <= '0;
         out_valid_ff  <= 1'b0;
         out_index_ff  <= '0;
         for (int k = 0; k < 8; k++) begin
            chain_ff[k] <= INIT_HASH[k];
         end
      end else begin
         bit_length_ff <= bit_length_in;
         out_valid_ff  <= out_valid_in;
         out_index_ff  <= out_index_in;
         for (int k = 0; k < 8; k++) begin
            chain_ff[k] <= chain_in[k];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      for (int k = 0; k < 8; k++) begin
         v_ff[k]      <= v_in[k];
         digest_ff[k] <= digest_in[k];
      end
   end

   assign status.out_busy = out_valid_ff;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = {5'b00000, out_index_ff, digest_ff[0]};
   assign rsp_tlast       = (out_index_ff == LAST_WORD);

endmodule

// ----- src/sha256_message_hasher.sv -----
// SHA-256 hasher for a byte stream.
// The request channel carries one message byte per transaction in req_tdata;
// req_tuser marks the byte as part of the message and req_tlast ends the
// message after this transaction, so an empty message is a single transaction
// with req_tuser low and req_tlast high.
// The response channel returns the eight digest words, word 0 first, with
// req_tlast's counterpart rsp_tlast on word 7.
// A byte is taken in each transaction while a block fills. The 64th byte
// of a block starts 64 compression rounds, done by the single round adder
// chain, and a chaining step, during which req_tready is low.
// At the end of a message the padding bytes are shifted in one per cycle
// except while a full block compresses or the length field begins, and
// one or two more compressions follow. The digest then drains from its own
// output register, so the next message can load while words wait.
// If the receiver stalls, the words hold; a further final block waits
// before its chaining step until the previous digest has gone out.
// Reset returns the chain to the initial hash values and clears the length,
// the fill position and the output.
module sha256_message_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word, word_index, zero fill
   output logic        rsp_tlast    // last_word
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer for loading, padding and rounds.
   sha256_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Block window, round logic, chain and digest output.
   sha256_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/sha256_checker.sv -----
module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled digest word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled digest word changed");

   // Digest words follow each other without a gap and in index order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[34:32] == 3'($past(rsp_tdata[34:32]) + 3'd1)))
      else $error("digest word out of order");

   // The last flag marks word seven and only word seven.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last flag does not match word index");

   // Reset leaves the block ready with no output pending.
   assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // A transaction with no byte and no end of message starts no work.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !req_tlast |=> req_tready)
      else $error("empty transaction stalled the input");

endmodule

bind sha256_message_hasher sha256_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
